// ===== hdl/pdhe_pkg.sv =====
package pdhe_pkg;

    // default field geometry
    localparam int POS_BITS_DEF  = 24;
    localparam int VEL_FRAC_DEF  = 16;

    localparam int TIME_W   = 32;
    localparam int VEL_W    = 32;
    localparam int HALF_W   = TIME_W / 2;
    localparam int PROD_W   = VEL_W + HALF_W + 1;
    localparam int ACC_W    = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;
    localparam logic [ACC_W-1:0] VEL_MAX_MAG = 64'h0000_0000_7FFF_FFFF;
    localparam logic [ACC_W-1:0] VEL_MIN_MAG = 64'h0000_0000_8000_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREDICT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_GAP = 3'd4;

    // register reset values
    localparam logic [TIME_W-1:0] STALE_RST   = 32'd500000;
    localparam logic [TIME_W-1:0] HOLD_RST    = 32'd100000;
    localparam logic [TIME_W-1:0] PREDICT_RST = 32'd350000;
    localparam logic [TIME_W-1:0] MIN_GAP_RST = 32'd1000;
    localparam logic [TIME_W-1:0] MAX_GAP_RST = 32'd1000000;

    typedef enum logic [1:0] {
        MODE_FRESH = 2'd0,
        MODE_HOLD  = 2'd1,
        MODE_EXT   = 2'd2,
        MODE_LOST  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_STORE,
        OP_VEL,
        OP_EXT
    } lane_op_t;

    typedef struct packed {
        lane_op_t            op;
        logic [TIME_W-1:0]   gap;
        logic [TIME_W-1:0]   age;
    } lane_cmd_t;

    typedef struct packed {
        logic                load;
        mode_t               mode;
        logic [TIME_W-1:0]   stamp;
    } merge_ctl_t;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_DIV,
        LN_DIVFIX,
        LN_MUL,
        LN_SUM,
        LN_ADD
    } lane_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT,
        ST_OUT
    } top_state_t;

endpackage

// ===== hdl/pdhe_lane.sv =====
module pdhe_lane
    import pdhe_pkg::*;
#(
    parameter int POS_BITS      = POS_BITS_DEF,
    parameter int VEL_FRAC_BITS = VEL_FRAC_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_cmd_t                  cmd,
    input  logic signed [POS_BITS-1:0] pos,
    output logic signed [POS_BITS-1:0] stored_pos,
    output logic signed [POS_BITS-1:0] ext_pos,
    output logic                       busy
);

    localparam int DW = POS_BITS + 1;
    localparam int NW = DW + VEL_FRAC_BITS;
    localparam int CW = $clog2(NW);
    localparam logic signed [ACC_W-1:0] PMAX = (64'sd1 <<< (POS_BITS - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] PMIN = -PMAX - 64'sd1;

    lane_state_t state_reg, state_next;

    logic signed [POS_BITS-1:0] stored_reg;
    logic signed [VEL_W-1:0]    vel_reg;
    logic [CW-1:0]              cnt_reg;

    logic [TIME_W-1:0]          gap_reg;
    logic [TIME_W-1:0]          age_reg;
    logic [NW-1:0]              num_reg;
    logic [NW-1:0]              quo_reg;
    logic [TIME_W-1:0]          rem_reg;
    logic                       neg_reg;
    logic signed [PROD_W-1:0]   plo_reg;
    logic signed [PROD_W-1:0]   phi_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [POS_BITS-1:0] ext_reg;

    logic signed [DW-1:0]       diff;
    logic [DW-1:0]              diff_mag;
    logic [TIME_W:0]            trial;
    logic [TIME_W:0]            rem_sub;
    logic                       fits;
    logic [ACC_W-1:0]           mag64;
    logic [VEL_W-1:0]           vel_sat;
    logic signed [PROD_W-1:0]   plo;
    logic signed [PROD_W-1:0]   phi;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    ext_sum;
    logic signed [POS_BITS-1:0] ext_clip;

    // difference to the stored position, sign and magnitude
    assign diff     = DW'(pos) - DW'(stored_reg);
    assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);

    // one restoring division step per cycle
    assign trial   = {rem_reg, num_reg[NW-1]};
    assign fits    = trial >= {1'b0, gap_reg};
    assign rem_sub = trial - {1'b0, gap_reg};

    assign mag64 = ACC_W'(quo_reg);
    always_comb
    begin
        if (neg_reg)
            vel_sat = (mag64 > VEL_MIN_MAG) ? VEL_MIN : VEL_W'(-mag64[VEL_W-1:0]);
        else
            vel_sat = (mag64 > VEL_MAX_MAG) ? VEL_MAX : mag64[VEL_W-1:0];
    end

    // velocity times age, split into two half-width products
    assign plo = vel_reg * $signed({1'b0, age_reg[HALF_W-1:0]});
    assign phi = vel_reg * $signed({1'b0, age_reg[TIME_W-1:HALF_W]});
    assign acc_sum = ACC_W'(plo_reg) + (ACC_W'(phi_reg) <<< HALF_W);

    assign ext_sum = ACC_W'(stored_reg) + (acc_reg >>> VEL_FRAC_BITS);
    always_comb
    begin
        if (ext_sum > PMAX)
            ext_clip = PMAX[POS_BITS-1:0];
        else if (ext_sum < PMIN)
            ext_clip = PMIN[POS_BITS-1:0];
        else
            ext_clip = ext_sum[POS_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LN_IDLE:
            begin
                if (cmd.op == OP_VEL)
                    state_next = LN_DIV;
                else if (cmd.op == OP_EXT)
                    state_next = LN_MUL;
            end
            LN_DIV:
            begin
                if (cnt_reg == CW'(NW - 1))
                    state_next = LN_DIVFIX;
            end
            LN_DIVFIX: state_next = LN_IDLE;
            LN_MUL:    state_next = LN_SUM;
            LN_SUM:    state_next = LN_ADD;
            LN_ADD:    state_next = LN_IDLE;
            default:   state_next = LN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= LN_IDLE;
            stored_reg <= '0;
            vel_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == LN_IDLE && cmd.op == OP_STORE)
                stored_reg <= pos;
            if (state_reg == LN_IDLE)
                cnt_reg <= '0;
            else if (state_reg == LN_DIV)
                cnt_reg <= cnt_reg + CW'(1);
            if (state_reg == LN_DIVFIX)
            begin
                vel_reg    <= vel_sat;
                stored_reg <= pos;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LN_IDLE:
            begin
                gap_reg <= cmd.gap;
                age_reg <= cmd.age;
                neg_reg <= diff[DW-1];
                num_reg <= {diff_mag, {VEL_FRAC_BITS{1'b0}}};
                rem_reg <= '0;
                quo_reg <= '0;
            end
            LN_DIV:
            begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                quo_reg <= {quo_reg[NW-2:0], fits};
                rem_reg <= fits ? rem_sub[TIME_W-1:0] : trial[TIME_W-1:0];
            end
            LN_MUL:
            begin
                plo_reg <= plo;
                phi_reg <= phi;
            end
            LN_SUM: acc_reg <= acc_sum;
            LN_ADD: ext_reg <= ext_clip;
            default: ;
        endcase
    end

    assign stored_pos = stored_reg;
    assign ext_pos    = ext_reg;
    assign busy       = (state_reg != LN_IDLE);

endmodule

// ===== hdl/pdhe_merge.sv =====
module pdhe_merge
    import pdhe_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  merge_ctl_t                 ctl,
    input  logic signed [POS_BITS-1:0] fresh_pos  [3],
    input  logic signed [POS_BITS-1:0] stored_pos [3],
    input  logic signed [POS_BITS-1:0] ext_pos    [3],
    output logic                       can_load,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic                       out_valid,
    output logic [1:0]                 out_mode,
    output logic [TIME_W-1:0]          out_time_us,
    output logic signed [POS_BITS-1:0] out_x_um,
    output logic signed [POS_BITS-1:0] out_y_um,
    output logic signed [POS_BITS-1:0] out_z_um
);

    logic                       full_reg;
    mode_t                      mode_reg;
    logic [TIME_W-1:0]          time_reg;
    logic signed [POS_BITS-1:0] pos_reg [3];
    logic signed [POS_BITS-1:0] pos_sel [3];

    // pick each axis from the source named by the mode
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (ctl.mode)
                MODE_FRESH: pos_sel[i] = fresh_pos[i];
                MODE_HOLD:  pos_sel[i] = stored_pos[i];
                MODE_EXT:   pos_sel[i] = ext_pos[i];
                default:    pos_sel[i] = '0;
            endcase
        end
    end

    assign can_load = !full_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (ctl.load)
            full_reg <= 1'b1;
        else if (!result_stall)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mode_reg <= ctl.mode;
            time_reg <= ctl.stamp;
            for (int i = 0; i < 3; i++)
                pos_reg[i] <= pos_sel[i];
        end
    end

    assign result_valid = full_reg;
    assign out_valid    = (mode_reg != MODE_LOST);
    assign out_mode     = mode_reg;
    assign out_time_us  = time_reg;
    assign out_x_um     = pos_reg[0];
    assign out_y_um     = pos_reg[1];
    assign out_z_um     = pos_reg[2];

endmodule

// ===== hdl/pose_dropout_hold_and_extrapolate_core.sv =====
// channel   direction  handshake                      payload
// item      in         item_valid / item_stall        sample_valid, sample_time_us,
//                                                     sample_x_um/y_um/z_um, current_time_us
// result    out        result_valid / result_stall    out_valid, out_mode, out_time_us,
//                                                     out_x_um/y_um/z_um
// config    in         cfg_write (no wait)            cfg_index, cfg_data
//
// one transaction at a time: accept, check, lane work, then the result register
// fresh sample with velocity update: runs the bit-serial divider in each axis lane,
//   one quotient bit a cycle, then stores the new velocity and position
// extrapolation: split multiply, sum, shift-add-clip in each axis lane
// next transaction is taken once the result sits in the output register
// rst_n clears the registers to their reset values, the track and axis state to zero
// a stalled result holds its register; a finished transaction waits until it frees up
module pose_dropout_hold_and_extrapolate_core
    import pdhe_pkg::*;
#(
    parameter int POS_BITS      = POS_BITS_DEF,
    parameter int VEL_FRAC_BITS = VEL_FRAC_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [TIME_W-1:0]          cfg_data,
    // input transactions
    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic                       sample_valid,
    input  logic [TIME_W-1:0]          sample_time_us,
    input  logic signed [POS_BITS-1:0] sample_x_um,
    input  logic signed [POS_BITS-1:0] sample_y_um,
    input  logic signed [POS_BITS-1:0] sample_z_um,
    input  logic [TIME_W-1:0]          current_time_us,
    // result transactions
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic                       out_valid,
    output logic [1:0]                 out_mode,
    output logic [TIME_W-1:0]          out_time_us,
    output logic signed [POS_BITS-1:0] out_x_um,
    output logic signed [POS_BITS-1:0] out_y_um,
    output logic signed [POS_BITS-1:0] out_z_um
);

    // configuration registers
    logic [TIME_W-1:0] stale_reg;
    logic [TIME_W-1:0] hold_reg;
    logic [TIME_W-1:0] predict_reg;
    logic [TIME_W-1:0] min_gap_reg;
    logic [TIME_W-1:0] max_gap_reg;

    // sequencer and track state
    top_state_t        state_reg, state_next;
    logic              have_track_reg;
    logic [TIME_W-1:0] stored_time_reg;
    mode_t             mode_reg;

    // captured transaction
    logic                       smp_valid_reg;
    logic [TIME_W-1:0]          smp_time_reg;
    logic [TIME_W-1:0]          now_reg;
    logic signed [POS_BITS-1:0] pos_reg [3];

    // decision terms
    logic [TIME_W-1:0] stale_age;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] age;
    logic              fresh;
    logic              vel_ok;
    logic              in_hold;
    logic              in_predict;
    mode_t             mode_sel;

    // lanes and merge
    lane_cmd_t                  lane_cmd;
    logic [2:0]                 lane_busy;
    logic signed [POS_BITS-1:0] lane_stored [3];
    logic signed [POS_BITS-1:0] lane_ext    [3];
    merge_ctl_t                 mctl;
    logic                       can_load;
    logic                       accept;

    assign accept = item_valid && !item_stall;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg   <= STALE_RST;
            hold_reg    <= HOLD_RST;
            predict_reg <= PREDICT_RST;
            min_gap_reg <= MIN_GAP_RST;
            max_gap_reg <= MAX_GAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_STALE:   stale_reg   <= cfg_data;
                CFG_HOLD:    hold_reg    <= cfg_data;
                CFG_PREDICT: predict_reg <= cfg_data;
                CFG_MIN_GAP: min_gap_reg <= cfg_data;
                CFG_MAX_GAP: max_gap_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // all time differences wrap modulo 2^32
    assign stale_age  = now_reg - smp_time_reg;
    assign gap        = smp_time_reg - stored_time_reg;
    assign age        = now_reg - stored_time_reg;
    assign fresh      = smp_valid_reg && (stale_age <= stale_reg);
    assign vel_ok     = have_track_reg && (gap > min_gap_reg) && (gap < max_gap_reg);
    assign in_hold    = have_track_reg && (age <= hold_reg);
    assign in_predict = have_track_reg && (age <= predict_reg);

    // hold is tested before predict, so misordered limits leave no window
    always_comb
    begin
        if (fresh)
            mode_sel = MODE_FRESH;
        else if (in_hold)
            mode_sel = MODE_HOLD;
        else if (in_predict)
            mode_sel = MODE_EXT;
        else
            mode_sel = MODE_LOST;
    end

    always_comb
    begin
        state_next   = state_reg;
        item_stall   = 1'b1;
        lane_cmd.op  = OP_NONE;
        lane_cmd.gap = gap;
        lane_cmd.age = age;
        mctl.load    = 1'b0;
        mctl.mode    = mode_reg;
        mctl.stamp   = (mode_reg == MODE_FRESH) ? smp_time_reg : now_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // first sample of a track is stored with the velocity left alone
                if (mode_sel == MODE_FRESH)
                    lane_cmd.op = vel_ok ? OP_VEL : OP_STORE;
                else if (mode_sel == MODE_EXT)
                    lane_cmd.op = OP_EXT;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (lane_busy == 3'b000)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (can_load)
                begin
                    mctl.load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            have_track_reg  <= 1'b0;
            stored_time_reg <= '0;
            mode_reg        <= MODE_LOST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CHECK)
            begin
                mode_reg <= mode_sel;
                if (fresh)
                begin
                    have_track_reg  <= 1'b1;
                    stored_time_reg <= smp_time_reg;
                end
            end
        end
    end

    // capture the transaction payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_valid_reg <= sample_valid;
            smp_time_reg  <= sample_time_us;
            now_reg       <= current_time_us;
            pos_reg[0]    <= sample_x_um;
            pos_reg[1]    <= sample_y_um;
            pos_reg[2]    <= sample_z_um;
        end
    end

    // one lane per axis: stored position, velocity, divider and multiplier
    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        pdhe_lane #(
            .POS_BITS      (POS_BITS),
            .VEL_FRAC_BITS (VEL_FRAC_BITS)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (lane_cmd),
            .pos        (pos_reg[g]),
            .stored_pos (lane_stored[g]),
            .ext_pos    (lane_ext[g]),
            .busy       (lane_busy[g])
        );
    end

    // merge the lane results into the result register
    pdhe_merge #(
        .POS_BITS (POS_BITS)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (mctl),
        .fresh_pos    (pos_reg),
        .stored_pos   (lane_stored),
        .ext_pos      (lane_ext),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_valid    (out_valid),
        .out_mode     (out_mode),
        .out_time_us  (out_time_us),
        .out_x_um     (out_x_um),
        .out_y_um     (out_y_um),
        .out_z_um     (out_z_um)
    );

endmodule
